FILE: rtl/multi_channel_byte_fifo_defines.svh
// ---------------------------------------------------------------------------
// multi_channel_byte_fifo_defines.svh
// Assertion macros used by the checker file of the byte FIFO block.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_BYTE_FIFO_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mcbf_pkg.sv
// ---------------------------------------------------------------------------
// mcbf_pkg
// Sizes, codes and shared types of the multi-channel byte FIFO.
// ---------------------------------------------------------------------------
package mcbf_pkg;

	localparam int NUM_PIPES = 8;
	localparam int MAX_DEPTH = 64;

	// Fixed field widths of the item ports.
	localparam int OP_W    = 2;
	localparam int PID_W   = 4;
	localparam int DATA_W  = 8;
	localparam int OSIZE_W = 7;
	localparam int STAT_W  = 3;

	// Widths that follow from the sizes.
	localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int ID_W   = $clog2(NUM_PIPES + 1);
	localparam int PTR_W  = $clog2(MAX_DEPTH);
	localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_PIPES * MAX_DEPTH);
	localparam int STORE_DEPTH = NUM_PIPES * MAX_DEPTH;
	localparam int CMP_W  = (PID_W > ID_W) ? PID_W : ID_W;
	localparam int SZ_W   = (OSIZE_W > LVL_W) ? OSIZE_W : LVL_W;

	typedef enum logic [OP_W-1:0] {
		OP_OPEN  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_DONE  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_EOD    = 3'd1,
		ST_BAD    = 3'd2,
		ST_FULL   = 3'd3,
		ST_EMPTY  = 3'd4,
		ST_NOFREE = 3'd5
	} status_t;

	// Outcome of one item, handed from the pipe table to the datapath.
	typedef struct packed {
		status_t           status;
		logic [PID_W-1:0]  new_id;
		logic              mem_wr;
		logic              mem_rd;
		logic [ADDR_W-1:0] addr;
	} mcbf_res_t;

endpackage

FILE: rtl/multi_channel_byte_fifo.sv
// ---------------------------------------------------------------------------
// multi_channel_byte_fifo
// Manager for up to NUM_PIPES byte pipes, each a ring buffer in a shared RAM.
// ---------------------------------------------------------------------------
// Usage: an item on the input channel (op, pipe_id, write_data, open_size)
// opens a pipe, writes a byte, reads a byte or closes a pipe for writing.
// Every item gives exactly one result item (status, new_id, read_data) on the
// output channel, in order. Both channels use valid and stall.
// There are two register stages. The item is registered, decided against the
// pipe table while the RAM is addressed, and the result lands in the output
// register together with the RAM read data. Throughput is one item per cycle
// when out_stall is low; the pipe table is updated at the edge the item leaves
// the input register, so the next item always sees fresh pointers.
// When out_stall is high with a result waiting, the result and the RAM read
// register hold; the input register still fills once, then in_stall rises.
// Reset empties both registers, clears all pipes and the id counter. The byte
// store needs no clearing, since only written bytes are ever read.
// ---------------------------------------------------------------------------
module multi_channel_byte_fifo
	import mcbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    op,
	input  logic [PID_W-1:0]   pipe_id,
	input  logic [DATA_W-1:0]  write_data,
	input  logic [OSIZE_W-1:0] open_size,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [PID_W-1:0]   new_id,
	output logic [DATA_W-1:0]  read_data
);

	logic               valid_s1;
	op_t                op_s1;
	logic [PID_W-1:0]   pipe_id_s1;
	logic [DATA_W-1:0]  write_data_s1;
	logic [OSIZE_W-1:0] open_size_s1;

	logic               valid_s2;
	status_t            status_s2;
	logic [PID_W-1:0]   new_id_s2;
	logic               rd_s2;

	logic               adv_s1;
	logic               fire;
	mcbf_res_t          res;
	logic [DATA_W-1:0]  ram_rdata;

	assign adv_s1   = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			op_s1         <= op_t'(op);
			pipe_id_s1    <= pipe_id;
			write_data_s1 <= write_data;
			open_size_s1  <= open_size;
		end
		if (adv_s1) begin
			status_s2 <= res.status;
			new_id_s2 <= res.new_id;
			rd_s2     <= res.mem_rd;
		end
	end

	mcbf_pipe_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op_s1),
		.pipe_id   (pipe_id_s1),
		.open_size (open_size_s1),
		.res       (res)
	);

	// The read register only loads on a taken read, so it holds under a stall.
	mcbf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (fire && res.mem_wr),
		.wr_addr (res.addr),
		.wr_data (write_data_s1),
		.rd_en   (fire && res.mem_rd),
		.rd_addr (res.addr),
		.rd_data (ram_rdata)
	);

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign new_id    = new_id_s2;
	assign read_data = rd_s2 ? ram_rdata : '0;

endmodule

FILE: rtl/mcbf_ram.sv
// ---------------------------------------------------------------------------
// mcbf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mcbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/mcbf_pipe_table.sv
// ---------------------------------------------------------------------------
// mcbf_pipe_table
// Per-pipe pointers, fill levels and flags; decides the outcome of one item.
// ---------------------------------------------------------------------------
module mcbf_pipe_table
	import mcbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  op_t                op,
	input  logic [PID_W-1:0]   pipe_id,
	input  logic [OSIZE_W-1:0] open_size,
	output mcbf_res_t          res
);

	logic [PTR_W-1:0] head_q  [NUM_PIPES];
	logic [PTR_W-1:0] tail_q  [NUM_PIPES];
	logic [LVL_W-1:0] fill_q  [NUM_PIPES];
	logic [LVL_W-1:0] cap_q   [NUM_PIPES];
	logic             wrable_q [NUM_PIPES];
	logic [ID_W-1:0]  id_count_q;

	logic [CMP_W-1:0]  pid_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic              id_ok;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] open_slot;
	logic [SZ_W-1:0]   osz;
	logic [LVL_W-1:0]  cap_new;
	logic [LVL_W-1:0]  head_inc;
	logic [LVL_W-1:0]  tail_inc;
	logic [PTR_W-1:0]  head_nxt;
	logic [PTR_W-1:0]  tail_nxt;
	logic              do_open;
	logic              do_write;
	logic              do_read;
	logic              do_close;

	always_comb begin
		pid_ext   = CMP_W'(pipe_id);
		cnt_ext   = CMP_W'(id_count_q);
		id_ok     = (pid_ext != '0) && (pid_ext <= cnt_ext);
		slot      = SLOT_W'(pid_ext - CMP_W'(1));
		open_slot = SLOT_W'(id_count_q);

		// A zero size is taken as one byte, anything past the region as full depth.
		osz = SZ_W'(open_size);
		if (osz == '0) begin
			osz = SZ_W'(1);
		end else if (osz > SZ_W'(MAX_DEPTH)) begin
			osz = SZ_W'(MAX_DEPTH);
		end
		cap_new = LVL_W'(osz);

		head_inc = LVL_W'(head_q[slot]) + LVL_W'(1);
		tail_inc = LVL_W'(tail_q[slot]) + LVL_W'(1);
		head_nxt = (head_inc >= cap_q[slot]) ? '0 : PTR_W'(head_inc);
		tail_nxt = (tail_inc >= cap_q[slot]) ? '0 : PTR_W'(tail_inc);
	end

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		do_open    = 1'b0;
		do_write   = 1'b0;
		do_read    = 1'b0;
		do_close   = 1'b0;
		unique case (op)
			OP_OPEN: begin
				if (id_count_q >= ID_W'(NUM_PIPES)) begin
					res.status = ST_NOFREE;
				end else begin
					do_open    = 1'b1;
					res.new_id = PID_W'(id_count_q + ID_W'(1));
				end
			end
			OP_WRITE: begin
				if (!id_ok || !wrable_q[slot]) begin
					res.status = ST_BAD;
				end else if (fill_q[slot] >= cap_q[slot]) begin
					res.status = ST_FULL;
				end else begin
					do_write   = 1'b1;
					res.mem_wr = 1'b1;
				end
			end
			OP_READ: begin
				if (!id_ok) begin
					res.status = ST_BAD;
				end else if (fill_q[slot] == '0) begin
					res.status = wrable_q[slot] ? ST_EMPTY : ST_EOD;
				end else begin
					do_read    = 1'b1;
					res.mem_rd = 1'b1;
				end
			end
			OP_DONE: begin
				if (!id_ok || !wrable_q[slot]) begin
					res.status = ST_BAD;
				end else begin
					do_close = 1'b1;
				end
			end
			default: begin
				res.status = ST_BAD;
			end
		endcase
		res.addr = ADDR_W'(slot) * ADDR_W'(MAX_DEPTH)
			+ ADDR_W'(do_write ? tail_q[slot] : head_q[slot]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_count_q <= '0;
			for (int i = 0; i < NUM_PIPES; i++) begin
				head_q[i]   <= '0;
				tail_q[i]   <= '0;
				fill_q[i]   <= '0;
				cap_q[i]    <= '0;
				wrable_q[i] <= 1'b0;
			end
		end else if (fire) begin
			if (do_open) begin
				head_q[open_slot]   <= '0;
				tail_q[open_slot]   <= '0;
				fill_q[open_slot]   <= '0;
				cap_q[open_slot]    <= cap_new;
				wrable_q[open_slot] <= 1'b1;
				id_count_q          <= id_count_q + ID_W'(1);
			end
			if (do_write) begin
				tail_q[slot] <= tail_nxt;
				fill_q[slot] <= fill_q[slot] + LVL_W'(1);
			end
			if (do_read) begin
				head_q[slot] <= head_nxt;
				fill_q[slot] <= fill_q[slot] - LVL_W'(1);
			end
			if (do_close) begin
				wrable_q[slot] <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/mcbf_checker.sv
// ---------------------------------------------------------------------------
// mcbf_checker
// Port-level checks of the multi-channel byte FIFO, bound to the top level.
// ---------------------------------------------------------------------------
`include "multi_channel_byte_fifo_defines.svh"

module mcbf_checker
	import mcbf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [OP_W-1:0]    op,
	input logic [PID_W-1:0]   pipe_id,
	input logic [DATA_W-1:0]  write_data,
	input logic [OSIZE_W-1:0] open_size,
	input logic               out_valid,
	input logic               out_stall,
	input logic [STAT_W-1:0]  status,
	input logic [PID_W-1:0]   new_id,
	input logic [DATA_W-1:0]  read_data
);

	// A result that is not ok carries neither an id nor a byte.
	`MCBF_ASSERT_NOW(a_err_clean, clk, arst_n, out_valid && (status != ST_OK), (new_id == '0) && (read_data == '0), "failed item carries payload")

	// An id is only handed out by a successful open, never with a read byte.
	`MCBF_ASSERT_NOW(a_id_ok, clk, arst_n, out_valid && (new_id != '0), (status == ST_OK) && (read_data == '0), "new id on bad result")

	// A waiting result holds still while the receiver stalls.
	`MCBF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(new_id) && $stable(read_data), "stalled result changed")

	// The input side only stalls while a result is blocked at the output.
	`MCBF_ASSERT_NOW(a_in_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

	// A stalled input item stays offered and unchanged.
	`MCBF_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(op) && $stable(pipe_id) && $stable(write_data) && $stable(open_size), "stalled input item changed")

endmodule

bind multi_channel_byte_fifo mcbf_checker u_mcbf_checker (.*);
